/* rtl/n_queens_solution_enumerator_assert.svh */
// assertion macros for the n-queens enumerator checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_ASSERT_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define NQSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define NQSE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/nqse_pkg.sv */
// shared constants, types and command/status structs of the n-queens enumerator
// no dependencies
`default_nettype none

package nqse_pkg;

  // largest board the row memory holds
  localparam int MAX_BOARD = 16;
  // the candidate column counter reaches board side plus one
  localparam int ROW_W = $clog2(MAX_BOARD + 2);
  localparam int IDX_W = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;

  // fixed field widths of the ports
  localparam int FIELD_W    = 5;
  localparam int CFG_W      = 5;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 16;
  localparam logic [CFG_W-1:0] BOARD_RESET = CFG_W'(8);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_BT,
    ST_CHK,
    ST_PLACE,
    ST_EMIT_RQ,
    ST_EMIT_WT,
    ST_EXH
  } state_e;

  // row memory read address sources
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_BT,
    RD_J,
    RD_R
  } rd_sel_e;

  typedef struct packed {
    logic    start;
    logic    set_exh;
    logic    row_dec;
    logic    row_inc;
    logic    cand_one;
    logic    cand_inc;
    logic    cand_load;
    logic    j_init;
    logic    j_inc;
    logic    r_init;
    logic    r_inc;
    logic    ram_we;
    logic    ram_re;
    rd_sel_e rd_sel;
    logic    out_sol;
    logic    out_exh;
  } ctl_cmd_t;

  typedef struct packed {
    logic active;
    logic done;
    logic n_zero;
    logic row_out;
    logic cand_over;
    logic row_is_one;
    logic row_is_n;
    logic conflict;
    logic j_last;
    logic r_is_n;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

/* rtl/nqse_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module nqse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds data while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/nqse_ctrl.sv */
// search sequencer of the n-queens enumerator
// depends on nqse_pkg
`default_nettype none

module nqse_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              s_restart_i,
  output logic                   s_ready_o,
  input  wire nqse_pkg::ctl_sts_t sts_i,
  output nqse_pkg::ctl_cmd_t     cmd_o
);

  nqse_pkg::state_e state_q, state_d;
  logic             accept;
  logic             restart_eff;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nqse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o   = (state_q == nqse_pkg::ST_IDLE);
  assign accept      = s_valid_i & s_ready_o;
  assign restart_eff = s_restart_i | ~sts_i.active;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = nqse_pkg::RD_ZERO;
    unique case (state_q)
      nqse_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.start = restart_eff;
          if (sts_i.n_zero || (sts_i.done && !restart_eff)) begin
            state_d = nqse_pkg::ST_EXH;
          end else begin
            state_d = nqse_pkg::ST_ADV;
          end
        end
      end
      // top of the backtracking loop
      nqse_pkg::ST_ADV: begin
        if (sts_i.row_out) begin
          state_d = nqse_pkg::ST_EXH;
        end else if (sts_i.cand_over) begin
          cmd_o.row_dec = 1'b1;
          if (sts_i.row_is_one) begin
            state_d = nqse_pkg::ST_ADV;
          end else begin
            cmd_o.ram_re = 1'b1;
            cmd_o.rd_sel = nqse_pkg::RD_BT;
            state_d      = nqse_pkg::ST_BT;
          end
        end else if (sts_i.row_is_one) begin
          state_d = nqse_pkg::ST_PLACE;
        end else begin
          cmd_o.j_init = 1'b1;
          cmd_o.ram_re = 1'b1;
          cmd_o.rd_sel = nqse_pkg::RD_ZERO;
          state_d      = nqse_pkg::ST_CHK;
        end
      end
      // resume the previous row after its stored column
      nqse_pkg::ST_BT: begin
        cmd_o.cand_load = 1'b1;
        state_d         = nqse_pkg::ST_ADV;
      end
      // one earlier row checked per cycle, next read issued alongside
      nqse_pkg::ST_CHK: begin
        if (sts_i.conflict) begin
          cmd_o.cand_inc = 1'b1;
          state_d        = nqse_pkg::ST_ADV;
        end else if (sts_i.j_last) begin
          state_d = nqse_pkg::ST_PLACE;
        end else begin
          cmd_o.j_inc  = 1'b1;
          cmd_o.ram_re = 1'b1;
          cmd_o.rd_sel = nqse_pkg::RD_J;
          state_d      = nqse_pkg::ST_CHK;
        end
      end
      nqse_pkg::ST_PLACE: begin
        cmd_o.ram_we = 1'b1;
        if (sts_i.row_is_n) begin
          cmd_o.cand_inc = 1'b1;
          cmd_o.r_init   = 1'b1;
          state_d        = nqse_pkg::ST_EMIT_RQ;
        end else begin
          cmd_o.row_inc  = 1'b1;
          cmd_o.cand_one = 1'b1;
          state_d        = nqse_pkg::ST_ADV;
        end
      end
      // emit the solution one row at a time
      nqse_pkg::ST_EMIT_RQ: begin
        cmd_o.ram_re = 1'b1;
        cmd_o.rd_sel = nqse_pkg::RD_R;
        state_d      = nqse_pkg::ST_EMIT_WT;
      end
      nqse_pkg::ST_EMIT_WT: begin
        if (sts_i.out_free) begin
          cmd_o.out_sol = 1'b1;
          if (sts_i.r_is_n) begin
            state_d = nqse_pkg::ST_IDLE;
          end else begin
            cmd_o.r_inc = 1'b1;
            state_d     = nqse_pkg::ST_EMIT_RQ;
          end
        end
      end
      nqse_pkg::ST_EXH: begin
        if (sts_i.out_free) begin
          cmd_o.set_exh = 1'b1;
          cmd_o.out_exh = 1'b1;
          state_d       = nqse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nqse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nqse_dpath.sv */
// datapath of the n-queens enumerator: counters, row memory, safety test, output register
// depends on nqse_pkg and nqse_ram
`default_nettype none

module nqse_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nqse_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire nqse_pkg::ctl_cmd_t             cmd_i,
  output nqse_pkg::ctl_sts_t                  sts_o,
  input  wire logic                           m_ready_i,
  output logic                                m_valid_o,
  output logic [nqse_pkg::FIELD_W-1:0]        m_row_o,
  output logic [nqse_pkg::FIELD_W-1:0]        m_col_o,
  output logic                                m_last_o,
  output logic                                m_exh_o
);

  logic [nqse_pkg::CFG_W-1:0] board_q;
  logic [nqse_pkg::ROW_W-1:0] side;
  logic [nqse_pkg::ROW_W-1:0] row_q, cand_q, j_q, r_q;
  logic                       active_q, done_q;
  logic [nqse_pkg::ROW_W-1:0] rdata;
  logic [nqse_pkg::ROW_W-1:0] rd_addr_full, wr_addr_full;
  logic [nqse_pkg::ROW_W-1:0] diff, row_gap;
  logic                       out_valid_q;
  logic [nqse_pkg::FIELD_W-1:0] out_row_q, out_col_q;
  logic                       out_last_q, out_exh_q;
  logic                       out_free;

  // board side, saturated to the memory depth
  assign side = (32'(board_q) > 32'(nqse_pkg::MAX_BOARD)) ?
                nqse_pkg::ROW_W'(nqse_pkg::MAX_BOARD) : nqse_pkg::ROW_W'(board_q);

  // board size register; a write ends the running search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q  <= nqse_pkg::BOARD_RESET;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (cfg_we_i) begin
      board_q  <= cfg_wdata_i;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (cmd_i.start) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
    end else if (cmd_i.set_exh) begin
      done_q <= 1'b1;
    end
  end

  // current row and candidate column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      cand_q <= '0;
    end else begin
      if (cmd_i.start) begin
        row_q <= nqse_pkg::ROW_W'(1);
      end else if (cmd_i.set_exh) begin
        row_q <= '0;
      end else if (cmd_i.row_dec) begin
        row_q <= row_q - 1'b1;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + 1'b1;
      end
      if (cmd_i.start || cmd_i.cand_one) begin
        cand_q <= nqse_pkg::ROW_W'(1);
      end else if (cmd_i.set_exh) begin
        cand_q <= '0;
      end else if (cmd_i.cand_load) begin
        cand_q <= rdata + 1'b1;
      end else if (cmd_i.cand_inc) begin
        cand_q <= cand_q + 1'b1;
      end
    end
  end

  // earlier-row counter of the safety test and row counter of the emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
      r_q <= '0;
    end else begin
      if (cmd_i.j_init) begin
        j_q <= nqse_pkg::ROW_W'(1);
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.r_init) begin
        r_q <= nqse_pkg::ROW_W'(1);
      end else if (cmd_i.r_inc) begin
        r_q <= r_q + 1'b1;
      end
    end
  end

  // row memory addressing
  always_comb begin
    case (cmd_i.rd_sel)
      nqse_pkg::RD_ZERO: rd_addr_full = '0;
      nqse_pkg::RD_BT:   rd_addr_full = row_q - nqse_pkg::ROW_W'(2);
      nqse_pkg::RD_J:    rd_addr_full = j_q;
      nqse_pkg::RD_R:    rd_addr_full = r_q - 1'b1;
      default:           rd_addr_full = '0;
    endcase
  end
  assign wr_addr_full = row_q - 1'b1;

  nqse_ram #(
    .WIDTH (nqse_pkg::ROW_W),
    .DEPTH (nqse_pkg::MAX_BOARD)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (wr_addr_full[nqse_pkg::IDX_W-1:0]),
    .wdata_i (cand_q),
    .re_i    (cmd_i.ram_re),
    .raddr_i (rd_addr_full[nqse_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // same column or same diagonal as earlier row j
  assign diff    = (rdata > cand_q) ? (rdata - cand_q) : (cand_q - rdata);
  assign row_gap = row_q - j_q;

  // output register, frees the search from the downstream stall
  assign out_free = ~out_valid_q | m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_sol || cmd_i.out_exh) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_sol) begin
      out_row_q  <= nqse_pkg::FIELD_W'(r_q);
      out_col_q  <= nqse_pkg::FIELD_W'(rdata);
      out_last_q <= (r_q == side);
      out_exh_q  <= 1'b0;
    end else if (cmd_i.out_exh) begin
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_last_q <= 1'b1;
      out_exh_q  <= 1'b1;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_row_o   = out_row_q;
  assign m_col_o   = out_col_q;
  assign m_last_o  = out_last_q;
  assign m_exh_o   = out_exh_q;

  // status toward the sequencer
  always_comb begin
    sts_o.active     = active_q;
    sts_o.done       = done_q;
    sts_o.n_zero     = (side == '0);
    sts_o.row_out    = (row_q == '0) || (row_q > side);
    sts_o.cand_over  = (cand_q > side);
    sts_o.row_is_one = (row_q == nqse_pkg::ROW_W'(1));
    sts_o.row_is_n   = (row_q == side);
    sts_o.conflict   = (rdata == cand_q) || (diff == row_gap);
    sts_o.j_last     = (nqse_pkg::ROW_W'(j_q + 1'b1) == row_q);
    sts_o.r_is_n     = (r_q == side);
    sts_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

/* rtl/n_queens_solution_enumerator.sv */
// top level of the n-queens solution enumerator
// depends on nqse_pkg, nqse_ctrl, nqse_dpath (and nqse_ram below it)
//
// channel   direction  fields (lsb first)
// s_axis    in         tdata: restart[0], zero pad to 8 bits
// m_axis    out        tdata: row_index[4:0], column[9:5], zero pad to 16; tlast: last;
//                      tuser: exhausted
// cfg       in         cfg_wdata_i: board_size, written when cfg_we_i is high
//
// one request at a time; s_axis_tready is high only while the sequencer is idle
// each candidate column of row r costs one row-memory read per earlier row
// backtracking one row reads back the previous row's stored column; each emitted row is read, then waits on the output
// no clearing pass after reset
// the output register holds a result while m_axis_tready is low and the search waits on it
`default_nettype none

module n_queens_solution_enumerator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // board size register write
  input  wire logic                             cfg_we_i,
  input  wire logic [nqse_pkg::CFG_W-1:0]       cfg_wdata_i,
  // request transaction
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [nqse_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [0] restart
  // result transaction
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [nqse_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [4:0] row_index, [9:5] column
  output logic                                  m_axis_tlast,  // last
  output logic [0:0]                            m_axis_tuser   // [0] exhausted
);

  nqse_pkg::ctl_cmd_t           cmd;
  nqse_pkg::ctl_sts_t           sts;
  logic [nqse_pkg::FIELD_W-1:0] out_row, out_col;
  logic                         out_exh;

  // sequencer
  nqse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_restart_i (s_axis_tdata[0]),
    .s_ready_o   (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  nqse_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_row_o     (out_row),
    .m_col_o     (out_col),
    .m_last_o    (m_axis_tlast),
    .m_exh_o     (out_exh)
  );

  // result packing
  assign m_axis_tdata = nqse_pkg::M_TDATA_W'({out_col, out_row});
  assign m_axis_tuser = out_exh;

endmodule

`default_nettype wire

/* rtl/nqse_checker.sv */
// port-level checks of the n-queens enumerator, bound to the top level
// depends on nqse_pkg and n_queens_solution_enumerator_assert.svh
`default_nettype none

`include "n_queens_solution_enumerator_assert.svh"

module nqse_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [nqse_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tlast,
  input wire logic [0:0]                     m_axis_tuser
);

  logic                           in_txn;
  logic                           res_exh;
  logic                           res_exh_ok;
  logic                           res_sol;
  logic                           res_zero;
  logic                           res_stall;
  logic [nqse_pkg::M_TDATA_W+1:0] res_bundle;

  assign in_txn     = s_axis_tvalid & s_axis_tready;
  assign res_exh    = m_axis_tvalid & m_axis_tuser[0];
  assign res_exh_ok = m_axis_tlast & (m_axis_tdata == '0);
  assign res_sol    = m_axis_tvalid & ~m_axis_tuser[0];
  assign res_zero   = (m_axis_tdata[4:0] == '0) | (m_axis_tdata[9:5] == '0);
  assign res_stall  = m_axis_tvalid & ~m_axis_tready;
  assign res_bundle = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  // an accepted request closes the input until its answer is worked out
  `NQSE_ASSERT(a_one_request, in_txn |=> !s_axis_tready, "request accepted while busy")

  // an exhausted result is a single, marked, all-zero item
  `NQSE_ASSERT(a_exh_shape, res_exh |-> res_exh_ok, "malformed exhausted result")

  // a placement row carries a nonzero row and column
  `NQSE_ASSERT_NEVER(a_sol_zero, res_sol && res_zero, "placement with zero row or column")

  // a stalled result holds
  `NQSE_ASSERT(a_out_hold, res_stall |=> m_axis_tvalid && $stable(res_bundle), "held result changed")

endmodule

bind n_queens_solution_enumerator nqse_checker u_nqse_checker (.*);

`default_nettype wire

/* verif/n_queens_solution_enumerator_checker.sv */
// scoreboard for the n-queens enumerator: tracks the board size register, predicts
// each request's placement rows and compares them with the result transactions
// depends on nqse_pkg
module n_queens_solution_enumerator_checker
  import nqse_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [0] restart
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic [M_TDATA_W-1:0] m_axis_tdata,   // [4:0] row_index, [9:5] column
  input  wire logic                 m_axis_tlast,   // last
  input  wire logic [0:0]           m_axis_tuser,   // [0] exhausted
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [FIELD_W-1:0] row_index;
    logic [FIELD_W-1:0] column;
    logic               last;
    logic               exhausted;
  } queen_row_t;

  // rows still owed by the block, oldest first
  queen_row_t expected_rows_q[$];

  // mirror of the block's search state
  logic [CFG_W-1:0] board_size_q;
  int               queen_col [MAX_BOARD];
  int               row_at;
  int               next_col;
  bit               search_on;
  bit               search_spent;

  function automatic int board_side();
    return (board_size_q > MAX_BOARD) ? MAX_BOARD : int'(board_size_q);
  endfunction

  // no earlier row shares the column or a diagonal
  function automatic bit column_free(int r, int c);
    int p;
    int gap;
    for (int j = 1; j < r; j++) begin
      p = queen_col[j-1];
      gap = (p > c) ? p - c : c - p;
      if (p == c || gap == r - j) return 1'b0;
    end
    return 1'b1;
  endfunction

  // depth-first walk until the next full board or the tree is spent
  function automatic bit next_placement(int n);
    while (row_at != 0 && row_at <= n) begin
      if (next_col > n) begin
        row_at--;
        if (row_at >= 1) next_col = queen_col[row_at-1] + 1;
      end else if (column_free(row_at, next_col)) begin
        queen_col[row_at-1] = next_col;
        if (row_at == n) begin
          next_col++;
          return 1'b1;
        end
        row_at++;
        next_col = 1;
      end else begin
        next_col++;
      end
    end
    return 1'b0;
  endfunction

  // queue the rows that one request transaction should produce
  function automatic void predict_placement(logic restart);
    int         n;
    queen_row_t row;
    n = board_side();
    if (restart || !search_on) begin
      search_on    = 1'b1;
      search_spent = 1'b0;
      row_at       = 1;
      next_col     = 1;
    end
    if (!search_spent && n > 0 && next_placement(n)) begin
      for (int r = 1; r <= n; r++) begin
        row.row_index = FIELD_W'(r);
        row.column    = FIELD_W'(queen_col[r-1]);
        row.last      = (r == n);
        row.exhausted = 1'b0;
        expected_rows_q.push_back(row);
      end
    end else begin
      search_spent = 1'b1;
      row_at       = 0;
      next_col     = 0;
      row          = '0;
      row.last      = 1'b1;
      row.exhausted = 1'b1;
      expected_rows_q.push_back(row);
    end
  endfunction

  function automatic void field_check(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  // compare one result transaction with the oldest owed row
  function automatic void check_row();
    queen_row_t want;
    if (expected_rows_q.size() == 0) begin
      $error("result transaction with nothing pending: tdata=%h tlast=%b tuser=%b",
             m_axis_tdata, m_axis_tlast, m_axis_tuser);
      fail_count_o++;
    end else begin
      want = expected_rows_q.pop_front();
      field_check("row_index", want.row_index, m_axis_tdata[4:0]);
      field_check("column", want.column, m_axis_tdata[9:5]);
      field_check("last", want.last, m_axis_tlast);
      field_check("exhausted", want.exhausted, m_axis_tuser[0]);
      field_check("tdata padding", 0, m_axis_tdata[M_TDATA_W-1:10]);
    end
  endfunction

  // results first, so a request taken at the same edge cannot match them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q = BOARD_RESET;
      foreach (queen_col[i]) queen_col[i] = 0;
      row_at       = 0;
      next_col     = 0;
      search_on    = 1'b0;
      search_spent = 1'b0;
      expected_rows_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_row();
      if (s_axis_tvalid && s_axis_tready) predict_placement(s_axis_tdata[0]);
      // a register write drops the running search
      if (cfg_we_i) begin
        board_size_q = cfg_wdata_i;
        search_on    = 1'b0;
        search_spent = 1'b0;
      end
      pending_o = expected_rows_q.size();
    end
  end

endmodule

/* verif/n_queens_solution_enumerator_tb.sv */
// testbench top for the n-queens enumerator: clock, reset, request and result traffic
// depends on nqse_pkg, n_queens_solution_enumerator and its checker
module n_queens_solution_enumerator_tb;
  import nqse_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 8_000_000;
  localparam int RANDOM_ITEMS  = 300;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [0] restart
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // [4:0] row_index, [9:5] column
  logic                 m_axis_tlast;         // last
  logic [0:0]           m_axis_tuser;         // [0] exhausted

  int fail_count;
  int rows_pending;
  int src_idle_pct  = 34;
  int sink_idle_pct = 87;
  bit sink_hold_req = 1'b0;
  int stall_cycles  = 0;

  n_queens_solution_enumerator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  n_queens_solution_enumerator_checker placement_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .fail_count_o(fail_count),
    .pending_o(rows_pending)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random backpressure, or a long hold when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // offer one request transaction, with a random gap in front
  task automatic send_request(input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(restart);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop offering and wait until every owed row has come back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rows_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // board size write, only once the block is idle
  task automatic write_board(input logic [CFG_W-1:0] size);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int               left;
    int               burst;
    int               roll;
    logic [CFG_W-1:0] size_pick;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // continue with no search started, at the reset board size, then the next placement
    send_request(1'b0);
    send_request(1'b0);
    // empty board is exhausted at once
    write_board(5'd0);
    send_request(1'b0);
    send_request(1'b1);
    // single square, then repeated exhaustion
    write_board(5'd1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // boards with no placement
    write_board(5'd2);
    send_request(1'b0);
    write_board(5'd3);
    send_request(1'b1);
    // both 4x4 solutions, exhaustion, restart, while the result side holds off
    write_board(5'd4);
    sink_hold_req = 1'b1;
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    // largest board
    write_board(5'd16);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    // oversize value saturates; the write drops the running search
    write_board(5'd31);
    send_request(1'b0);
    send_request(1'b0);

    // random traffic in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 34;
          sink_idle_pct = 87;
        end
        1: begin
          src_idle_pct  = 87;
          sink_idle_pct = 34;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      left = RANDOM_ITEMS / 3;
      while (left > 0) begin
        // mostly small boards so searches run out and restart often
        roll = $urandom_range(99);
        if (roll < 4) begin
          size_pick = '0;
        end else if (roll < 16) begin
          size_pick = CFG_W'($urandom_range(12, 9));
        end else begin
          size_pick = CFG_W'($urandom_range(8, 1));
        end
        write_board(size_pick);
        burst = $urandom_range(20, 4);
        if (burst > left) burst = left;
        repeat (burst) send_request($urandom_range(99) < 8);
        left -= burst;
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
